>>> design/atids_pkg.sv
// Package for the array table: sizes, opcode and status codes, sequencer states
// and the control struct shared by the sequencer and the entry cells.
// No dependencies.
`default_nettype none
package atids_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PTR_W    = CNT_W + 1;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 5;
    localparam int POS_W    = 4;
    localparam int STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [ADDR_W-1:0] idx;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/array_table_insert_delete_search_top.sv
// Top level of the array table: sequencer plus entry cell row.
// Depends on atids_pkg, atids_ctrl, atids_cells.
`default_nettype none
// Holds up to 16 signed 32-bit entries and a fill count. Insert and delete shift the
// cell row in a single register update; their result is valid in S_RESP, after the
// S_EXEC state, and with no output stall the next word is accepted back in S_IDLE.
// Search runs a binary search through one signed comparator, one probe per cycle,
// in S_PROBE: up to 5 probes on a full table, plus one more S_PROBE visit to see
// the range empty when the key is missing. One word is in flight at a time:
// s_ready is high only when no result is pending.
module array_table_insert_delete_search_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [atids_pkg::OP_W-1:0]          s_opcode,
    input  wire logic [atids_pkg::IDX_W-1:0]         s_index,
    input  wire logic signed [atids_pkg::DATA_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [atids_pkg::STAT_W-1:0]             m_status,
    output logic                                     m_found,
    output logic [atids_pkg::POS_W-1:0]              m_position,
    output logic signed [atids_pkg::DATA_W-1:0]      m_removed_value,
    output logic [atids_pkg::CNT_W-1:0]              m_count
);

    atids_pkg::cell_ctrl_t          cell_ctrl;
    logic [atids_pkg::DATA_W-1:0]   rdata;

    atids_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_index         (s_index),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found         (m_found),
        .m_position      (m_position),
        .m_removed_value (m_removed_value),
        .m_count         (m_count),
        .cell_ctrl       (cell_ctrl),
        .rdata           (rdata)
    );

    atids_cells u_cells (
        .aclk  (aclk),
        .ctrl  (cell_ctrl),
        .rdata (rdata)
    );

endmodule
`default_nettype wire

>>> design/atids_cells.sv
// Row of entry cells: registered shift up on insert, shift down on delete,
// one muxed read port. Depends on atids_pkg.
`default_nettype none
module atids_cells (
    input  wire logic                        aclk,
    input  wire atids_pkg::cell_ctrl_t       ctrl,
    output logic [atids_pkg::DATA_W-1:0]     rdata
);

    logic [atids_pkg::DATA_W-1:0] entry_reg  [atids_pkg::CAPACITY];
    logic [atids_pkg::DATA_W-1:0] entry_next [atids_pkg::CAPACITY];

    always_comb begin
        for (int i = 0; i < atids_pkg::CAPACITY; i++) begin
            entry_next[i] = entry_reg[i];
            if (ctrl.ins_en) begin
                if (atids_pkg::ADDR_W'(i) == ctrl.idx) begin
                    entry_next[i] = ctrl.wdata;
                end else if (i > 0 && atids_pkg::ADDR_W'(i) > ctrl.idx) begin
                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (ctrl.del_en) begin
                if (i < atids_pkg::CAPACITY - 1 && atids_pkg::ADDR_W'(i) >= ctrl.idx) begin
                    entry_next[i] = entry_reg[(i < atids_pkg::CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < atids_pkg::CAPACITY; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign rdata = entry_reg[ctrl.raddr];

endmodule
`default_nettype wire

>>> design/atids_ctrl.sv
// Sequencer: decodes the word, checks bounds, keeps the fill count and runs the
// binary search through one shared signed compare. Depends on atids_pkg.
`default_nettype none
module atids_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [atids_pkg::OP_W-1:0]        s_opcode,
    input  wire logic [atids_pkg::IDX_W-1:0]       s_index,
    input  wire logic signed [atids_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [atids_pkg::STAT_W-1:0]           m_status,
    output logic                                   m_found,
    output logic [atids_pkg::POS_W-1:0]            m_position,
    output logic signed [atids_pkg::DATA_W-1:0]    m_removed_value,
    output logic [atids_pkg::CNT_W-1:0]            m_count,
    output atids_pkg::cell_ctrl_t                  cell_ctrl,
    input  wire logic [atids_pkg::DATA_W-1:0]      rdata
);

    atids_pkg::state_t                    state_reg, state_next;
    logic [atids_pkg::OP_W-1:0]           op_reg;
    logic [atids_pkg::IDX_W-1:0]          idx_reg;
    logic [atids_pkg::DATA_W-1:0]         val_reg;
    logic [atids_pkg::CNT_W-1:0]          count_reg, count_next;
    logic signed [atids_pkg::PTR_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [atids_pkg::STAT_W-1:0]         status_reg, status_next;
    logic                                 found_reg, found_next;
    logic [atids_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [atids_pkg::DATA_W-1:0]         removed_reg, removed_next;
    logic [atids_pkg::PTR_W:0]            mid_sum;
    logic signed [atids_pkg::PTR_W-1:0]   mid;
    logic                                 key_lt, key_eq;

    assign mid_sum = (atids_pkg::PTR_W + 1)'(lo_reg) + (atids_pkg::PTR_W + 1)'(hi_reg);
    assign mid     = atids_pkg::PTR_W'(mid_sum >> 1);
    assign key_eq  = (val_reg == rdata);
    assign key_lt  = ($signed(val_reg) < $signed(rdata));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atids_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_opcode;
            idx_reg <= s_index;
            val_reg <= s_value;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        removed_reg <= removed_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        removed_next    = removed_reg;
        cell_ctrl.ins_en = 1'b0;
        cell_ctrl.del_en = 1'b0;
        cell_ctrl.idx    = idx_reg[atids_pkg::ADDR_W-1:0];
        cell_ctrl.wdata  = val_reg;
        cell_ctrl.raddr  = idx_reg[atids_pkg::ADDR_W-1:0];
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        case (state_reg)
            atids_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = atids_pkg::S_EXEC;
                end
            end
            atids_pkg::S_EXEC: begin
                status_next  = atids_pkg::ST_DONE;
                found_next   = 1'b0;
                pos_next     = '0;
                removed_next = '0;
                lo_next      = '0;
                hi_next      = $signed({1'b0, count_reg}) - atids_pkg::PTR_W'(1);
                state_next   = atids_pkg::S_RESP;
                case (op_reg)
                    atids_pkg::OP_INSERT: begin
                        if (idx_reg > count_reg) begin
                            status_next = atids_pkg::ST_BAD_INDEX;
                        end else if (count_reg >= atids_pkg::CNT_W'(atids_pkg::CAPACITY)) begin
                            status_next = atids_pkg::ST_FULL;
                        end else begin
                            cell_ctrl.ins_en = 1'b1;
                            count_next       = count_reg + atids_pkg::CNT_W'(1);
                        end
                    end
                    atids_pkg::OP_DELETE: begin
                        if (idx_reg >= count_reg) begin
                            status_next = atids_pkg::ST_BAD_INDEX;
                        end else begin
                            removed_next     = rdata;
                            cell_ctrl.del_en = 1'b1;
                            count_next       = count_reg - atids_pkg::CNT_W'(1);
                        end
                    end
                    atids_pkg::OP_SEARCH: begin
                        state_next = atids_pkg::S_PROBE;
                    end
                    default: begin
                    end
                endcase
            end
            atids_pkg::S_PROBE: begin
                cell_ctrl.raddr = mid[atids_pkg::ADDR_W-1:0];
                if (lo_reg > hi_reg) begin
                    state_next = atids_pkg::S_RESP;
                end else if (key_eq) begin
                    found_next = 1'b1;
                    pos_next   = mid[atids_pkg::POS_W-1:0];
                    state_next = atids_pkg::S_RESP;
                end else if (key_lt) begin
                    hi_next = mid - atids_pkg::PTR_W'(1);
                end else begin
                    lo_next = mid + atids_pkg::PTR_W'(1);
                end
            end
            atids_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = atids_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = atids_pkg::S_IDLE;
            end
        endcase
    end

    assign m_status        = status_reg;
    assign m_found         = found_reg;
    assign m_position      = pos_reg;
    assign m_removed_value = removed_reg;
    assign m_count         = count_reg;

endmodule
`default_nettype wire
